// ===== rtl/core/bmhq_pkg.sv =====
`default_nettype none

package bmhq_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELMIN = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/bmhq_if.sv =====
`default_nettype none

// request channel: insert or delete-min
interface bmhq_in_if #(
    parameter int TAG_BITS = 8,
    parameter int KEY_BITS = 24
);
    import bmhq_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, opcode, tag, key, input ready);
    modport sink   (input valid, opcode, tag, key, output ready);
endinterface

// result channel
interface bmhq_out_if #(
    parameter int TAG_BITS = 8,
    parameter int KEY_BITS = 24,
    parameter int OCC_BITS = 7
);
    import bmhq_pkg::*;

    logic                valid;
    logic                ready;
    logic [TAG_BITS-1:0] out_tag;
    logic [KEY_BITS-1:0] out_key;
    t_status             status;
    logic [OCC_BITS-1:0] occupancy;

    modport source (output valid, out_tag, out_key, status, occupancy, input ready);
    modport sink   (input valid, out_tag, out_key, status, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmhq_ram.sv =====
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue.sv =====
`default_nettype none

// Channel   Dir  Payload                              Transfer
// i_in      in   opcode, tag, key                     valid & ready
// o_out     out  out_tag, out_key, status, occupancy  valid & ready
//
// One request at a time. Insert and delete-min walk the heap level by
// level, at most log2(CAPACITY) levels; the pace is set by the
// single read port of the entry RAM, one read per cycle, and the one shared
// key comparator. Refused or empty requests go straight to the finish state.
// Reset (synchronous, active low) empties the heap; RAM contents are not
// cleared, a fill count guards every read.
// i_in.ready is high only while the sequencer is idle. A result waiting on a
// stalled o_out does not block the next request; a further result waits
// in the finish state until the output register frees.
module binary_min_heap_queue #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 24,
    parameter int TAG_BITS = 8
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bmhq_in_if.sink   i_in,
    bmhq_out_if.source o_out
);
    import bmhq_pkg::*;

    localparam int OCC_BITS   = $clog2(CAPACITY + 1);  // fill count, slot numbers
    localparam int SLOT_BITS  = OCC_BITS + 1;          // child slot, may pass CAPACITY
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int ENTRY_BITS = TAG_BITS + KEY_BITS;   // {tag, key}

    // sequencer states
    typedef enum logic [9:0] {
        Q_IDLE    = 10'b0000000001,
        Q_UP      = 10'b0000000010,  // sift up: read parent, or place at root
        Q_UP_CMP  = 10'b0000000100,  // sift up: compare with parent
        Q_DN_LAST = 10'b0000001000,  // root back, read last slot
        Q_DN_MOV  = 10'b0000010000,  // last entry back
        Q_DN_RDL  = 10'b0000100000,  // sift down: read left child or stop
        Q_DN_RDR  = 10'b0001000000,  // left back, read right child
        Q_DN_PICK = 10'b0010000000,  // right back, pick smaller child
        Q_DN_CMP  = 10'b0100000000,  // compare moved entry with chosen child
        Q_FIN     = 10'b1000000000   // hand result to output register
    } t_state;

    t_state                r_state,     n_state;
    logic [OCC_BITS-1:0]   r_fill,      n_fill;
    logic [OCC_BITS-1:0]   r_pos,       n_pos;       // insert slot / delete parent
    logic [SLOT_BITS-1:0]  r_child,     n_child;
    logic [OCC_BITS-1:0]   r_cand_slot, n_cand_slot;
    logic [ENTRY_BITS-1:0] r_new,       n_new;       // entry being inserted
    logic [ENTRY_BITS-1:0] r_mov,       n_mov;       // entry moved down from last slot
    logic [ENTRY_BITS-1:0] r_cand,      n_cand;      // chosen child
    logic [ENTRY_BITS-1:0] r_top,       n_top;       // result entry
    t_status               r_status,    n_status;

    logic                  r_out_valid, n_out_valid;
    logic [TAG_BITS-1:0]   r_out_tag,   n_out_tag;
    logic [KEY_BITS-1:0]   r_out_key,   n_out_key;
    t_status               r_out_status, n_out_status;
    logic [OCC_BITS-1:0]   r_out_occ,   n_out_occ;

    // RAM port
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;

    // slot to address (slot 1 at address 0)
    logic [OCC_BITS-1:0]   w_pos_m1;
    logic [OCC_BITS-1:0]   w_par_m1;
    logic [OCC_BITS-1:0]   w_fill_m1;
    logic [SLOT_BITS-1:0]  w_child_m1;

    assign w_pos_m1   = r_pos - OCC_BITS'(1);
    assign w_par_m1   = (r_pos >> 1) - OCC_BITS'(1);
    assign w_fill_m1  = r_fill - OCC_BITS'(1);
    assign w_child_m1 = r_child - SLOT_BITS'(1);

    // shared key comparator: cmp_a < cmp_b
    logic [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                cmp_lt;

    always_comb begin
        case (r_state)
            Q_UP_CMP: begin
                cmp_a = r_new[KEY_BITS-1:0];
                cmp_b = ram_rdata[KEY_BITS-1:0];
            end
            Q_DN_PICK: begin
                cmp_a = ram_rdata[KEY_BITS-1:0];
                cmp_b = r_cand[KEY_BITS-1:0];
            end
            default: begin
                cmp_a = r_cand[KEY_BITS-1:0];
                cmp_b = r_mov[KEY_BITS-1:0];
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    bmhq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == Q_IDLE);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_child      = r_child;
        n_cand_slot  = r_cand_slot;
        n_new        = r_new;
        n_mov        = r_mov;
        n_cand       = r_cand;
        n_top        = r_top;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_tag    = r_out_tag;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        ram_we       = 1'b0;
        ram_waddr    = w_pos_m1[ADDR_BITS-1:0];
        ram_wdata    = r_mov;
        ram_raddr    = '0;

        // output register drains independently of the sequencer
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            Q_IDLE: begin
                if (i_in.valid) begin
                    n_new    = {i_in.tag, i_in.key};
                    n_top    = '0;
                    n_status = ST_OK;
                    if (i_in.opcode == OP_INSERT) begin
                        if (r_fill == OCC_BITS'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = Q_FIN;
                        end else begin
                            n_fill  = r_fill + OCC_BITS'(1);
                            n_pos   = r_fill + OCC_BITS'(1);
                            n_state = Q_UP;
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = Q_FIN;
                        end else begin
                            ram_raddr = '0;  // root
                            n_state   = Q_DN_LAST;
                        end
                    end
                end
            end
            Q_UP: begin
                if (r_pos == OCC_BITS'(1)) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_new;
                    n_state   = Q_FIN;
                end else begin
                    ram_raddr = w_par_m1[ADDR_BITS-1:0];
                    n_state   = Q_UP_CMP;
                end
            end
            Q_UP_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    // parent moves down one level
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos >> 1;
                    n_state   = Q_UP;
                end else begin
                    ram_wdata = r_new;
                    n_state   = Q_FIN;
                end
            end
            Q_DN_LAST: begin
                n_top     = ram_rdata;
                ram_raddr = w_fill_m1[ADDR_BITS-1:0];
                n_fill    = w_fill_m1;
                n_pos     = OCC_BITS'(1);
                n_child   = SLOT_BITS'(2);
                n_state   = Q_DN_MOV;
            end
            Q_DN_MOV: begin
                n_mov   = ram_rdata;
                n_state = Q_DN_RDL;
            end
            Q_DN_RDL: begin
                if (r_child > SLOT_BITS'(r_fill)) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_mov;
                    n_state   = Q_FIN;
                end else begin
                    ram_raddr = w_child_m1[ADDR_BITS-1:0];
                    n_state   = Q_DN_RDR;
                end
            end
            Q_DN_RDR: begin
                n_cand      = ram_rdata;
                n_cand_slot = r_child[OCC_BITS-1:0];
                if (r_child < SLOT_BITS'(r_fill)) begin
                    ram_raddr = r_child[ADDR_BITS-1:0];  // right child
                    n_state   = Q_DN_PICK;
                end else begin
                    n_state = Q_DN_CMP;
                end
            end
            Q_DN_PICK: begin
                // right only when left key is strictly greater
                if (cmp_lt) begin
                    n_cand      = ram_rdata;
                    n_cand_slot = r_child[OCC_BITS-1:0] + OCC_BITS'(1);
                end
                n_state = Q_DN_CMP;
            end
            Q_DN_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    // child key below moved key: child moves up
                    ram_wdata = r_cand;
                    n_pos     = r_cand_slot;
                    n_child   = {r_cand_slot, 1'b0};
                    n_state   = Q_DN_RDL;
                end else begin
                    ram_wdata = r_mov;
                    n_state   = Q_FIN;
                end
            end
            Q_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_tag    = r_top[ENTRY_BITS-1:KEY_BITS];
                    n_out_key    = r_top[KEY_BITS-1:0];
                    n_out_status = r_status;
                    n_out_occ    = r_fill;
                    n_state      = Q_IDLE;
                end
            end
            default: begin
                n_state = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= Q_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_child      <= n_child;
        r_cand_slot  <= n_cand_slot;
        r_new        <= n_new;
        r_mov        <= n_mov;
        r_cand       <= n_cand;
        r_top        <= n_top;
        r_status     <= n_status;
        r_out_tag    <= n_out_tag;
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_tag   = r_out_tag;
    assign o_out.out_key   = r_out_key;
    assign o_out.status    = r_out_status;
    assign o_out.occupancy = r_out_occ;

    // fill count stays within capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= OCC_BITS'(CAPACITY))
        else $error("fill count above capacity");

    // fill count moves by one at most
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
        ((r_fill == $past(r_fill) + OCC_BITS'(1)) ||
         (r_fill == $past(r_fill) - OCC_BITS'(1))))
        else $error("fill count jumped");

    // no RAM write while idle or handing over a result
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == Q_IDLE) || (r_state == Q_FIN)) |-> !ram_we)
        else $error("RAM write outside sift");

    // each result reports the occupancy it left
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == Q_FIN) && (!r_out_valid || o_out.ready)) |=>
        (r_out_valid && (r_out_occ == r_fill) && (r_state == Q_IDLE)))
        else $error("result not loaded");

endmodule

`default_nettype wire

// ===== sim/binary_min_heap_queue_test.sv =====
package bmhq_test_pkg;

    import bmhq_pkg::*;

    localparam int HEAP_DEPTH = 64;
    localparam int TAG_BITS   = 8;
    localparam int KEY_BITS   = 24;
    localparam int OCC_BITS   = 7;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] key;
    } t_heap_entry;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] key;
        t_status             status;
        logic [OCC_BITS-1:0] occupancy;
    } t_heap_result;

    // Shadow heap plus the queue of results still owed by the block.
    class heap_scoreboard;
        t_heap_entry  shadow_heap [1:HEAP_DEPTH];
        int unsigned  shadow_fill;
        t_heap_result owed_results [$];
        int unsigned  mismatch_count;

        function new();
            shadow_fill    = 0;
            mismatch_count = 0;
        endfunction

        // sift up while strictly smaller than the parent
        function void shadow_insert(t_heap_entry item);
            int unsigned pos;
            shadow_fill = shadow_fill + 1;
            pos = shadow_fill;
            while (pos != 1 && item.key < shadow_heap[pos / 2].key) begin
                shadow_heap[pos] = shadow_heap[pos / 2];
                pos = pos / 2;
            end
            shadow_heap[pos] = item;
        endfunction

        // last entry to the root, sift down; right child only on strict >
        function t_heap_entry shadow_extract_min();
            t_heap_entry top;
            t_heap_entry moved;
            int unsigned parent;
            int unsigned child;
            top    = shadow_heap[1];
            moved  = shadow_heap[shadow_fill];
            parent = 1;
            child  = 2;
            shadow_fill = shadow_fill - 1;
            while (child <= shadow_fill) begin
                if (child < shadow_fill &&
                    shadow_heap[child].key > shadow_heap[child + 1].key)
                    child = child + 1;
                if (moved.key <= shadow_heap[child].key)
                    break;
                shadow_heap[parent] = shadow_heap[child];
                parent = child;
                child  = child * 2;
            end
            shadow_heap[parent] = moved;
            return top;
        endfunction

        function void note_request(logic op, logic [TAG_BITS-1:0] tag,
                                   logic [KEY_BITS-1:0] key);
            t_heap_result want;
            t_heap_entry  item;
            want.tag    = '0;
            want.key    = '0;
            want.status = ST_OK;
            if (op == OP_INSERT) begin
                if (shadow_fill >= HEAP_DEPTH) begin
                    want.status = ST_FULL;
                end else begin
                    item.tag = tag;
                    item.key = key;
                    shadow_insert(item);
                end
            end else if (shadow_fill == 0) begin
                want.status = ST_EMPTY;
            end else begin
                item     = shadow_extract_min();
                want.tag = item.tag;
                want.key = item.key;
            end
            want.occupancy = OCC_BITS'(shadow_fill);
            owed_results.push_back(want);
        endfunction

        function void check_result(t_heap_result got);
            t_heap_result want;
            if (owed_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: tag=%0h key=%0h status=%0d occupancy=%0d",
                             got.tag, got.key, got.status, got.occupancy);
                return;
            end
            want = owed_results.pop_front();
            if (got.tag !== want.tag || got.key !== want.key ||
                got.status !== want.status || got.occupancy !== want.occupancy) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS) begin
                    $write("mismatch: expected tag=%0h key=%0h status=%0d occupancy=%0d, ",
                           want.tag, want.key, want.status, want.occupancy);
                    $display("got tag=%0h key=%0h status=%0d occupancy=%0d",
                             got.tag, got.key, got.status, got.occupancy);
                end
            end
        endfunction
    endclass

endpackage

module binary_min_heap_queue_test;

    import bmhq_pkg::*;
    import bmhq_test_pkg::*;

    // Watchdog limit: all transactions plus the long output hold and reset
    // fit many times over in this figure.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_ITEMS  = 950;
    localparam int unsigned HOLD_AT       = 150;   // results seen before the long hold
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 60;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

    // Random episode kinds: biased towards filling, draining, mixed, or
    // inserts only, which drives the heap into the full state.
    localparam int EP_FILL     = 0;
    localparam int EP_DRAIN    = 1;
    localparam int EP_MIXED    = 2;
    localparam int EP_SATURATE = 3;

    // Key ranges: a tiny range forces equal keys, a top range keeps the
    // upper bits set, the full range exercises every bit.
    localparam int KEYS_LOW  = 0;
    localparam int KEYS_HIGH = 1;
    localparam int KEYS_FULL = 2;

    logic i_clk;
    logic i_rst_n;

    bmhq_in_if  #(.TAG_BITS(TAG_BITS), .KEY_BITS(KEY_BITS)) req_ch ();
    bmhq_out_if #(.TAG_BITS(TAG_BITS), .KEY_BITS(KEY_BITS), .OCC_BITS(OCC_BITS)) res_ch ();

    binary_min_heap_queue #(
        .CAPACITY (HEAP_DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    heap_scoreboard board = new();

    int unsigned cycle_count    = 0;
    int unsigned received_count = 0;
    int unsigned random_sent    = 0;
    bit          hold_done      = 1'b0;
    bit          tx_burst       = 1'b0;    // sender offers back to back
    bit          rx_burst       = 1'b0;    // receiver adds no random stalls

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("binary_min_heap_queue_test NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [KEY_BITS-1:0] draw_key(int mode);
        case (mode)
            KEYS_LOW:  return KEY_BITS'($urandom_range(0, 7));
            KEYS_HIGH: return KEY_MAX - KEY_BITS'($urandom_range(0, 7));
            default:   return KEY_BITS'($urandom);
        endcase
    endfunction

    // Offer one transaction; entered and left at a falling edge. Inputs
    // change only at falling edges, ready is sampled at rising edges.
    task automatic send_request(input logic op, input logic [TAG_BITS-1:0] tag,
                                input logic [KEY_BITS-1:0] key);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.opcode = op;
        req_ch.tag    = tag;
        req_ch.key    = key;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(op, tag, key);
        @(negedge i_clk);
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
    endtask

    // One run of related transactions sharing a bias and a key range.
    task automatic run_episode(input int kind, input int unsigned count);
        int unsigned n;
        int          key_mode;
        int unsigned insert_pct;
        key_mode = $urandom_range(KEYS_LOW, KEYS_FULL);
        case (kind)
            EP_FILL:     insert_pct = 85;
            EP_DRAIN:    insert_pct = 15;
            EP_SATURATE: insert_pct = 100;
            default:     insert_pct = 50;
        endcase
        for (n = 0; n < count; n++) begin
            if ($urandom_range(1, 100) <= insert_pct)
                send_request(OP_INSERT, TAG_BITS'($urandom), draw_key(key_mode));
            else
                // delete fields are ignored by the block, so fill them with noise
                send_request(OP_DELMIN, TAG_BITS'($urandom), KEY_BITS'($urandom));
            random_sent = random_sent + 1;
        end
    endtask

    // Result side: random stalls, bursts without stalls, and one long hold
    // so that the block backs up and drops its input ready.
    initial begin
        int unsigned gap;
        t_heap_result got;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!hold_done && received_count == HOLD_AT) begin
                hold_done    = 1'b1;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.tag       = res_ch.out_tag;
            got.key       = res_ch.out_key;
            got.status    = res_ch.status;
            got.occupancy = res_ch.occupancy;
            board.check_result(got);
            received_count = received_count + 1;
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
        end
    end

    initial begin
        int kind;
        bit first_episode;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_INSERT;
        req_ch.tag    = '0;
        req_ch.key    = '0;
        i_rst_n       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: delete on an empty heap, key and tag extremes, equal
        // keys at a leaf and at the root, then drain past empty.
        send_request(OP_DELMIN, 8'hA5, 24'h123456);
        send_request(OP_INSERT, 8'hFF, 24'hFFFFFF);
        send_request(OP_INSERT, 8'h00, 24'h000000);
        send_request(OP_INSERT, 8'h11, 24'h000010);
        send_request(OP_INSERT, 8'h12, 24'h000010);
        send_request(OP_INSERT, 8'h13, 24'h000010);
        send_request(OP_INSERT, 8'h5A, 24'hAAAAAA);
        send_request(OP_INSERT, 8'hA5, 24'h555555);
        send_request(OP_INSERT, 8'h01, 24'h000000);
        repeat (9) send_request(OP_DELMIN, 8'h00, 24'h000000);

        // Random: the first episode fills the heap and hits the refusal on
        // full; the rest wander between full and empty.
        first_episode = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            if (first_episode) begin
                kind = EP_SATURATE;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: kind = EP_FILL;
                    3, 4, 5: kind = EP_DRAIN;
                    9:       kind = EP_SATURATE;
                    default: kind = EP_MIXED;
                endcase
            end
            first_episode = 1'b0;
            run_episode(kind, (kind == EP_SATURATE) ? 70 : $urandom_range(10, 80));
        end
        req_ch.valid = 1'b0;

        // Let every owed result arrive, then watch for strays.
        while (board.owed_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (board.mismatch_count == 0 && board.owed_results.size() == 0)
            $display("binary_min_heap_queue_test OK");
        else
            $display("binary_min_heap_queue_test NOT OK");
        $finish;
    end

endmodule
